[rtl/ccsc_pkg.sv]
`default_nettype none

package ccsc_pkg;

    // cubie counts and entry layout
    localparam int NUM_CORNERS   = 8;
    localparam int NUM_EDGES     = 12;
    localparam int CORNER_W      = 6;
    localparam int EDGE_W        = 5;
    localparam int CPOS_W        = 3;
    localparam int EPOS_W        = 4;
    localparam int ORI_W         = 3;
    localparam int CORNERS_W     = NUM_CORNERS * CORNER_W;
    localparam int EDGES_W       = NUM_EDGES * EDGE_W;
    localparam int ACTION_W      = 2;
    localparam int TWIST_W       = 12;
    localparam int FLIP_W        = 11;
    localparam int STATUS_W      = 3;
    localparam int EMASK_W       = 1 << EPOS_W;

    // coordinate spans
    localparam int TWIST_CORNERS = 7;
    localparam int FLIP_EDGES    = 11;

    // complete position sets
    localparam logic [EMASK_W-1:0]     FULL_EDGE_MASK   = 16'h0fff;
    localparam logic [NUM_CORNERS-1:0] FULL_CORNER_MASK = 8'hff;

    // base-3 place values, corner 0 most significant
    localparam logic [TWIST_W-1:0] TWIST_WEIGHT [TWIST_CORNERS] =
        '{12'd729, 12'd243, 12'd81, 12'd27, 12'd9, 12'd3, 12'd1};

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_MUL  = 2'd1,
        ACT_INV  = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_MISSING_EDGE   = 3'd1,
        ST_FLIP_PARITY    = 3'd2,
        ST_MISSING_CORNER = 3'd3,
        ST_TWIST          = 3'd4,
        ST_PERM_PARITY    = 3'd5
    } t_status;

    // twist of an orientation code, mirrored codes included
    function automatic logic [1:0] ori_mod3(input logic [ORI_W-1:0] o);
        logic [1:0] r;
        case (o) inside
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [1:0] neg_mod3(input logic [1:0] a);
        return (a == 2'd0) ? 2'd0 : 2'(2'd3 - a);
    endfunction

    function automatic logic [CORNERS_W-1:0] identity_corners();
        logic [CORNERS_W-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            v[i*CORNER_W +: CORNER_W] = CORNER_W'(i);
        end
        return v;
    endfunction

    function automatic logic [EDGES_W-1:0] identity_edges();
        logic [EDGES_W-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_EDGES; i++) begin
            v[i*EDGE_W +: EDGE_W] = {EPOS_W'(i), 1'b0};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/ccsc_if.sv]
`default_nettype none

// command channel: action and operand cube
interface ccsc_in_if;
    import ccsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [CORNERS_W-1:0] operand_corners;
    logic [EDGES_W-1:0]   operand_edges;

    modport source (output valid, output action, output operand_corners,
                    output operand_edges, input ready);
    modport sink   (input valid, input action, input operand_corners,
                    input operand_edges, output ready);
endinterface

// result channel: new state, coordinates and check status
interface ccsc_out_if;
    import ccsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CORNERS_W-1:0] state_corners;
    logic [EDGES_W-1:0]   state_edges;
    logic [TWIST_W-1:0]   twist_coord;
    logic [FLIP_W-1:0]    flip_coord;
    logic [STATUS_W-1:0]  check_status;

    modport source (output valid, output state_corners, output state_edges,
                    output twist_coord, output flip_coord, output check_status,
                    input ready);
    modport sink   (input valid, input state_corners, input state_edges,
                    input twist_coord, input flip_coord, input check_status,
                    output ready);
endinterface

`default_nettype wire

[rtl/cube_cubie_state_compose.sv]
// Stage 1 is the state register; stage 2, the result register, captures it with its checks.
// Throughput: one item per cycle unless the result stalls; the state register updates at the input
// transfer, so each item sees the state left by the one before it.
// Stage 2 (coordinates and checks) stalls only while the result waits.
// Reset (synchronous, active low) loads identity corners and edges, empties both stages.
`default_nettype none

module cube_cubie_state_compose
    import ccsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ccsc_in_if.sink      i_in,
    ccsc_out_if.source   o_out
);

    // held cube state and stage 1 occupancy
    logic [CORNERS_W-1:0] r_corners;
    logic [EDGES_W-1:0]   r_edges;
    logic                 r_s1_valid;

    // result register
    logic                 r_out_valid;
    logic [CORNERS_W-1:0] r_out_corners;
    logic [EDGES_W-1:0]   r_out_edges;
    logic [TWIST_W-1:0]   r_out_twist;
    logic [FLIP_W-1:0]    r_out_flip;
    logic [STATUS_W-1:0]  r_out_status;

    logic [CORNERS_W-1:0] n_corners;
    logic [EDGES_W-1:0]   n_edges;
    logic [TWIST_W-1:0]   n_twist;
    logic [FLIP_W-1:0]    n_flip;
    logic [STATUS_W-1:0]  n_status;

    logic                 in_xfer;
    logic                 s2_adv;

    // unpacked views of the held state and the operand
    logic [CORNER_W-1:0]  sc [NUM_CORNERS];
    logic [EDGE_W-1:0]    se [NUM_EDGES];
    logic [CORNER_W-1:0]  bc [NUM_CORNERS];
    logic [EDGE_W-1:0]    be [NUM_EDGES];

    // product and inverse
    logic [CORNERS_W-1:0] mul_corners;
    logic [EDGES_W-1:0]   mul_edges;
    logic [CORNER_W-1:0]  ic [NUM_CORNERS];
    logic [EDGE_W-1:0]    ie [NUM_EDGES];
    logic [CORNERS_W-1:0] inv_corners;
    logic [EDGES_W-1:0]   inv_edges;

    // handshake: stage 2 moves when the result register is free or drains
    assign s2_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s2_adv;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            sc[i] = r_corners[i*CORNER_W +: CORNER_W];
            bc[i] = i_in.operand_corners[i*CORNER_W +: CORNER_W];
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            se[i] = r_edges[i*EDGE_W +: EDGE_W];
            be[i] = i_in.operand_edges[i*EDGE_W +: EDGE_W];
        end
    end

    // right-multiply the state by the operand
    always_comb begin
        logic [CORNER_W-1:0] src_c;
        logic [ORI_W-1:0]    oa;
        logic [ORI_W-1:0]    ob;
        logic [1:0]          ra;
        logic [1:0]          rb;
        logic [1:0]          r;
        logic [ORI_W-1:0]    o;
        logic [EPOS_W-1:0]   p;
        logic [EDGE_W-1:0]   src_e;
        mul_corners = '0;
        mul_edges   = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            src_c = sc[bc[i][CPOS_W-1:0]];
            oa    = src_c[CORNER_W-1:CPOS_W];
            ob    = bc[i][CORNER_W-1:CPOS_W];
            ra    = ori_mod3(oa);
            rb    = ori_mod3(ob);
            // mirrored source turns the operand twist the other way
            r     = (oa < 3'd3) ? add_mod3(ra, rb) : add_mod3(ra, neg_mod3(rb));
            o     = {1'b0, r};
            if ((oa >= 3'd3) != (ob >= 3'd3)) begin
                o = o + 3'd3;
            end
            mul_corners[i*CORNER_W +: CORNER_W] = {o, src_c[CPOS_W-1:0]};
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            p     = be[i][EDGE_W-1:1];
            // a position past the last edge picks a zero entry
            src_e = (p < EPOS_W'(NUM_EDGES)) ? se[p] : '0;
            mul_edges[i*EDGE_W +: EDGE_W] = src_e ^ {{(EDGE_W-1){1'b0}}, be[i][0]};
        end
    end

    // invert the state; on repeated positions the higher source index wins
    always_comb begin
        logic [EPOS_W-1:0] p;
        logic [ORI_W-1:0]  o;
        logic [1:0]        r;
        logic [ORI_W-1:0]  n;
        for (int i = 0; i < NUM_EDGES; i++) begin
            ie[i] = {EPOS_W'(i), 1'b0};
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            ic[i] = CORNER_W'(i);
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            p = se[i][EDGE_W-1:1];
            if (p < EPOS_W'(NUM_EDGES)) begin
                ie[p] = {EPOS_W'(i), se[i][0]};
            end
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            o = sc[i][CORNER_W-1:CPOS_W];
            r = ori_mod3(o);
            n = (o >= 3'd3) ? ({1'b0, r} + 3'd3) : {1'b0, neg_mod3(r)};
            ic[sc[i][CPOS_W-1:0]] = {n, CPOS_W'(i)};
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            inv_corners[i*CORNER_W +: CORNER_W] = ic[i];
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            inv_edges[i*EDGE_W +: EDGE_W] = ie[i];
        end
    end

    // select the next state; the unused action holds it
    always_comb begin
        case (t_action'(i_in.action))
            ACT_LOAD: begin
                n_corners = i_in.operand_corners;
                n_edges   = i_in.operand_edges;
            end
            ACT_MUL: begin
                n_corners = mul_corners;
                n_edges   = mul_edges;
            end
            ACT_INV: begin
                n_corners = inv_corners;
                n_edges   = inv_edges;
            end
            default: begin
                n_corners = r_corners;
                n_edges   = r_edges;
            end
        endcase
    end

    // coordinates and checks of the held state
    always_comb begin
        logic [EMASK_W-1:0]     emask;
        logic [NUM_CORNERS-1:0] cmask;
        logic                   fsum;
        logic [1:0]             osum;
        logic                   par;
        emask   = '0;
        cmask   = '0;
        fsum    = 1'b0;
        osum    = 2'd0;
        par     = 1'b0;
        n_twist = '0;
        n_flip  = '0;
        for (int i = 0; i < TWIST_CORNERS; i++) begin
            n_twist = n_twist
                + TWIST_W'(TWIST_WEIGHT[i] * ori_mod3(sc[i][CORNER_W-1:CPOS_W]));
        end
        for (int i = 0; i < FLIP_EDGES; i++) begin
            n_flip[FLIP_EDGES-1-i] = se[i][0];
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            emask[se[i][EDGE_W-1:1]] = 1'b1;
            fsum = fsum ^ se[i][0];
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            cmask[sc[i][CPOS_W-1:0]] = 1'b1;
            osum = add_mod3(osum, ori_mod3(sc[i][CORNER_W-1:CPOS_W]));
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            for (int j = i + 1; j < NUM_EDGES; j++) begin
                if (se[i][EDGE_W-1:1] > se[j][EDGE_W-1:1]) begin
                    par = ~par;
                end
            end
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            for (int j = i + 1; j < NUM_CORNERS; j++) begin
                if (sc[i][CPOS_W-1:0] > sc[j][CPOS_W-1:0]) begin
                    par = ~par;
                end
            end
        end
        // report the first failing check
        if (emask != FULL_EDGE_MASK) begin
            n_status = ST_MISSING_EDGE;
        end else if (fsum) begin
            n_status = ST_FLIP_PARITY;
        end else if (cmask != FULL_CORNER_MASK) begin
            n_status = ST_MISSING_CORNER;
        end else if (osum != 2'd0) begin
            n_status = ST_TWIST;
        end else if (par) begin
            n_status = ST_PERM_PARITY;
        end else begin
            n_status = ST_OK;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corners   <= identity_corners();
            r_edges     <= identity_edges();
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_corners  <= n_corners;
                r_edges    <= n_edges;
                r_s1_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // capture the result payload as stage 1 advances
    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_out_corners <= r_corners;
            r_out_edges   <= r_edges;
            r_out_twist   <= n_twist;
            r_out_flip    <= n_flip;
            r_out_status  <= n_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.state_corners = r_out_corners;
    assign o_out.state_edges   = r_out_edges;
    assign o_out.twist_coord   = r_out_twist;
    assign o_out.flip_coord    = r_out_flip;
    assign o_out.check_status  = r_out_status;

    // a load transfer puts the operand into the held state
    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.action == ACT_LOAD) |=>
            (r_corners == $past(i_in.operand_corners)
             && r_edges == $past(i_in.operand_edges)))
        else $error("load did not replace the held state");

    // a stalled stage 1 keeps its item and the state
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_adv) |=> (r_s1_valid && $stable(r_corners) && $stable(r_edges)))
        else $error("stage 1 lost its item while stalled");

    // an advancing stage 1 item reaches the result register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_adv) |=> o_out.valid)
        else $error("stage 1 item did not reach the output");

    // input backpressure only when both stages are full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ccsc_pkg::*;

    // action code with no operation behind it
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [CORNERS_W-1:0] corners;
        logic [EDGES_W-1:0]   edges;
        logic [TWIST_W-1:0]   twist;
        logic [FLIP_W-1:0]    flip;
        logic [STATUS_W-1:0]  status;
    } t_cube_result;

    typedef enum int {
        CUBE_PLAIN,
        CUBE_MIRROR,
        CUBE_WILD
    } t_cube_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ccsc_in_if  cmd_ch ();
    ccsc_out_if res_ch ();

    t_cube_result         pending_cubes [$];
    logic [CORNERS_W-1:0] held_corners;
    logic [EDGES_W-1:0]   held_edges;
    int                   mismatches  = 0;
    int                   idle_cycles = 0;
    int                   sink_hold   = 0;
    bit                   steady_send = 1'b0;
    bit                   steady_sink = 1'b0;

    cube_cubie_state_compose dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CORNERS_W-1:0] home_corners();
        logic [CORNERS_W-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            v[i*CORNER_W +: CORNER_W] = CORNER_W'(i);
        end
        return v;
    endfunction

    function automatic logic [EDGES_W-1:0] home_edges();
        logic [EDGES_W-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_EDGES; i++) begin
            v[i*EDGE_W +: EDGE_W] = {EPOS_W'(i), 1'b0};
        end
        return v;
    endfunction

    function automatic logic [CORNERS_W-1:0] noise_corners();
        return CORNERS_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [EDGES_W-1:0] noise_edges();
        return EDGES_W'({$urandom(), $urandom()});
    endfunction

    // first failed check wins: edges, flips, corners, twist, parity
    function automatic logic [STATUS_W-1:0] cube_status(input logic [CORNERS_W-1:0] cv,
                                                        input logic [EDGES_W-1:0] ev);
        logic [EMASK_W-1:0]     emask;
        logic [NUM_CORNERS-1:0] cmask;
        logic                   fsum;
        logic                   par;
        int                     osum;
        emask = '0;
        cmask = '0;
        fsum  = 1'b0;
        par   = 1'b0;
        osum  = 0;
        for (int i = 0; i < NUM_EDGES; i++) begin
            emask[ev[i*EDGE_W+1 +: EPOS_W]] = 1'b1;
            fsum ^= ev[i*EDGE_W];
        end
        if (emask != FULL_EDGE_MASK) return ST_MISSING_EDGE;
        if (fsum) return ST_FLIP_PARITY;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            cmask[cv[i*CORNER_W +: CPOS_W]] = 1'b1;
            osum += cv[i*CORNER_W+CPOS_W +: ORI_W];
        end
        if (cmask != FULL_CORNER_MASK) return ST_MISSING_CORNER;
        if (osum % 3 != 0) return ST_TWIST;
        // count inversions over both permutations
        for (int i = 0; i < NUM_EDGES; i++) begin
            for (int j = i + 1; j < NUM_EDGES; j++) begin
                if (ev[i*EDGE_W+1 +: EPOS_W] > ev[j*EDGE_W+1 +: EPOS_W]) par = ~par;
            end
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            for (int j = i + 1; j < NUM_CORNERS; j++) begin
                if (cv[i*CORNER_W +: CPOS_W] > cv[j*CORNER_W +: CPOS_W]) par = ~par;
            end
        end
        return par ? ST_PERM_PARITY : ST_OK;
    endfunction

    // apply one action to the held cube and form the result it returns
    function automatic t_cube_result next_cube_result(input logic [ACTION_W-1:0] act,
                                                      input logic [CORNERS_W-1:0] opc,
                                                      input logic [EDGES_W-1:0] ope);
        t_cube_result         r;
        logic [CORNERS_W-1:0] nc;
        logic [EDGES_W-1:0]   ne;
        logic [CORNER_W-1:0]  a;
        logic [CORNER_W-1:0]  b;
        logic [EDGE_W-1:0]    x;
        logic [EDGE_W-1:0]    y;
        int                   oa;
        int                   ob;
        int                   o;
        int                   p;
        nc = held_corners;
        ne = held_edges;
        case (act)
            ACT_LOAD: begin
                nc = opc;
                ne = ope;
            end
            ACT_MUL: begin
                // corners: add twists mod 3, mirrored state subtracts
                for (int i = 0; i < NUM_CORNERS; i++) begin
                    b  = opc[i*CORNER_W +: CORNER_W];
                    a  = held_corners[b[CPOS_W-1:0]*CORNER_W +: CORNER_W];
                    oa = a[CORNER_W-1:CPOS_W];
                    ob = b[CORNER_W-1:CPOS_W];
                    o  = (oa < 3) ? (oa + ob) % 3 : (oa + 9 - ob) % 3;
                    if ((oa >= 3) != (ob >= 3)) o += 3;
                    nc[i*CORNER_W +: CORNER_W] = {ORI_W'(o), a[CPOS_W-1:0]};
                end
                // edges: positions past eleven pick an all-zero entry
                for (int i = 0; i < NUM_EDGES; i++) begin
                    y = ope[i*EDGE_W +: EDGE_W];
                    p = y[EDGE_W-1:1];
                    x = (p < NUM_EDGES) ? held_edges[p*EDGE_W +: EDGE_W] : '0;
                    ne[i*EDGE_W +: EDGE_W] = x ^ {{(EDGE_W-1){1'b0}}, y[0]};
                end
            end
            ACT_INV: begin
                // start from identity; later sources overwrite earlier ones
                nc = home_corners();
                ne = home_edges();
                for (int i = 0; i < NUM_EDGES; i++) begin
                    x = held_edges[i*EDGE_W +: EDGE_W];
                    p = x[EDGE_W-1:1];
                    if (p < NUM_EDGES) ne[p*EDGE_W +: EDGE_W] = {EPOS_W'(i), x[0]};
                end
                for (int i = 0; i < NUM_CORNERS; i++) begin
                    a  = held_corners[i*CORNER_W +: CORNER_W];
                    o  = a[CORNER_W-1:CPOS_W];
                    oa = o % 3;
                    ob = (o >= 3) ? oa + 3 : (3 - oa) % 3;
                    nc[a[CPOS_W-1:0]*CORNER_W +: CORNER_W] = {ORI_W'(ob), CPOS_W'(i)};
                end
            end
            default: begin
                // spare action holds the state
            end
        endcase
        held_corners = nc;
        held_edges   = ne;

        r.corners = nc;
        r.edges   = ne;
        r.twist   = '0;
        r.flip    = '0;
        for (int i = 0; i < TWIST_CORNERS; i++) begin
            r.twist = TWIST_W'(r.twist * 3 + (nc[i*CORNER_W+CPOS_W +: ORI_W] % 3));
        end
        for (int i = 0; i < FLIP_EDGES; i++) begin
            r.flip = {r.flip[FLIP_W-2:0], ne[i*EDGE_W]};
        end
        r.status = cube_status(nc, ne);
        return r;
    endfunction

    // random cube; plain and mirror kinds pass every check
    function automatic void random_cube(input t_cube_kind kind,
                                        output logic [CORNERS_W-1:0] cv,
                                        output logic [EDGES_W-1:0] ev);
        int cpos [NUM_CORNERS];
        int epos [NUM_EDGES];
        int ori  [NUM_CORNERS];
        int j;
        int t;
        int osum;
        bit cpar;
        bit epar;
        bit fsum;
        bit fl;
        cpar = 1'b0;
        epar = 1'b0;
        fsum = 1'b0;
        osum = 0;
        for (int i = 0; i < NUM_CORNERS; i++) cpos[i] = i;
        for (int i = 0; i < NUM_EDGES; i++) epos[i] = i;
        for (int i = NUM_CORNERS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            if (j != i) begin
                t = cpos[i]; cpos[i] = cpos[j]; cpos[j] = t;
                cpar = ~cpar;
            end
        end
        for (int i = NUM_EDGES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            if (j != i) begin
                t = epos[i]; epos[i] = epos[j]; epos[j] = t;
                epar = ~epar;
            end
        end
        // match the permutation parities
        if (cpar != epar) begin
            t = epos[0]; epos[0] = epos[1]; epos[1] = t;
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
            case (kind)
                CUBE_PLAIN:  ori[i] = $urandom_range(0, 2);
                CUBE_MIRROR: ori[i] = $urandom_range(0, 5);
                default:     ori[i] = $urandom_range(0, 7);
            endcase
            if (i < NUM_CORNERS - 1) osum += ori[i];
        end
        // close the twist sum on the last corner, keep its mirror flag
        if (kind != CUBE_WILD) begin
            ori[NUM_CORNERS-1] = ((ori[NUM_CORNERS-1] >= 3) ? 3 : 0) + (3 - osum % 3) % 3;
        end
        cv = '0;
        ev = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            cv[i*CORNER_W +: CORNER_W] = {ORI_W'(ori[i]), CPOS_W'(cpos[i])};
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            fl = 1'($urandom_range(0, 1));
            if (i == NUM_EDGES - 1 && kind != CUBE_WILD) fl = fsum;
            fsum ^= fl;
            ev[i*EDGE_W +: EDGE_W] = {EPOS_W'(epos[i]), fl};
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] %s mismatch: got %h, expected %h", $time, field, got, want);
        end
        mismatches++;
    endtask

    // drive one command; called and returns at a falling edge
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [CORNERS_W-1:0] opc,
                             input logic [EDGES_W-1:0] ope);
        int gap;
        gap = steady_send ? 0 : idle_len();
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid           = 1'b1;
        cmd_ch.action          = act;
        cmd_ch.operand_corners = opc;
        cmd_ch.operand_edges   = ope;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_cubes.push_back(next_cube_result(act, opc, ope));
        @(negedge i_clk);
    endtask

    // result sink with random stalls; hold ready low during reset
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold    = 0;
            res_ch.ready = 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold     = sink_hold - 1;
            res_ch.ready = 1'b0;
        end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
            sink_hold     = idle_len();
            res_ch.ready = 1'b0;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_cube_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_cubes.size() == 0) begin
                report_mismatch("result with nothing pending", res_ch.state_corners, '0);
            end else begin
                want = pending_cubes.pop_front();
                if (res_ch.state_corners !== want.corners)
                    report_mismatch("state_corners", res_ch.state_corners, want.corners);
                if (res_ch.state_edges !== want.edges)
                    report_mismatch("state_edges", res_ch.state_edges, want.edges);
                if (res_ch.twist_coord !== want.twist)
                    report_mismatch("twist_coord", res_ch.twist_coord, want.twist);
                if (res_ch.flip_coord !== want.flip)
                    report_mismatch("flip_coord", res_ch.flip_coord, want.flip);
                if (res_ch.check_status !== want.status)
                    report_mismatch("check_status", res_ch.check_status, want.status);
            end
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("cube_cubie_state_compose regression: fail");
                $finish;
            end
        end
    end

    // all-ones and all-zero cubes, identity, spare action
    task automatic test_extremes();
        send_item(ACT_INV, '0, '0);
        send_item(ACT_SPARE, '1, '1);
        send_item(ACT_MUL, home_corners(), home_edges());
        // edge positions past eleven and orientation seven in the operand
        send_item(ACT_MUL, '1, '1);
        send_item(ACT_INV, '0, '0);
        send_item(ACT_LOAD, '1, '1);
        // every entry names one position: for the corners the last source wins
        send_item(ACT_INV, '0, '0);
        send_item(ACT_LOAD, '0, '0);
        send_item(ACT_MUL, '1, '1);
        send_item(ACT_INV, '0, '0);
    endtask

    // one cube for each check status, then the largest coordinates
    task automatic test_check_status();
        logic [CORNERS_W-1:0] c;
        logic [EDGES_W-1:0]   e;
        c = home_corners();
        e = home_edges();
        send_item(ACT_LOAD, c, e);
        e[0] = 1'b1;
        send_item(ACT_LOAD, c, e);
        e = home_edges();
        e[EDGE_W +: EDGE_W] = '0;
        send_item(ACT_LOAD, c, e);
        e = home_edges();
        c[0 +: CPOS_W] = CPOS_W'(1);
        send_item(ACT_LOAD, c, e);
        c = home_corners();
        c[CPOS_W +: ORI_W] = ORI_W'(1);
        send_item(ACT_LOAD, c, e);
        c = home_corners();
        e[0 +: EDGE_W]      = {EPOS_W'(1), 1'b0};
        e[EDGE_W +: EDGE_W] = {EPOS_W'(0), 1'b0};
        send_item(ACT_LOAD, c, e);
        // twist two on corners 0..6, every edge flipped
        e = home_edges();
        for (int i = 0; i < NUM_CORNERS; i++) begin
            c[i*CORNER_W+CPOS_W +: ORI_W] = (i < TWIST_CORNERS) ? ORI_W'(2) : ORI_W'(1);
        end
        for (int i = 0; i < NUM_EDGES; i++) e[i*EDGE_W] = 1'b1;
        send_item(ACT_LOAD, c, e);
        send_item(ACT_INV, '0, '0);
    endtask

    // orientation codes six and seven and mirrored inverses
    task automatic test_orientation_codes();
        logic [CORNERS_W-1:0] c;
        logic [EDGES_W-1:0]   e;
        logic [CORNERS_W-1:0] mc;
        logic [EDGES_W-1:0]   me;
        c = home_corners();
        c[0*CORNER_W+CPOS_W +: ORI_W] = ORI_W'(6);
        c[1*CORNER_W+CPOS_W +: ORI_W] = ORI_W'(7);
        c[2*CORNER_W+CPOS_W +: ORI_W] = ORI_W'(5);
        e = home_edges();
        send_item(ACT_LOAD, c, e);
        send_item(ACT_INV, '0, '0);
        random_cube(CUBE_MIRROR, mc, me);
        send_item(ACT_MUL, mc, me);
        send_item(ACT_MUL, c, e);
        send_item(ACT_INV, '0, '0);
    endtask

    // load a cube, then run products, inverses, spare actions and reloads on it
    task automatic test_solvable_sequences();
        logic [CORNERS_W-1:0] c;
        logic [EDGES_W-1:0]   e;
        t_cube_kind           kind;
        int                   r;
        repeat (70) begin
            r    = $urandom_range(0, 9);
            kind = (r < 6) ? CUBE_PLAIN : (r < 9) ? CUBE_MIRROR : CUBE_WILD;
            random_cube(kind, c, e);
            send_item(ACT_LOAD, c, e);
            repeat ($urandom_range(4, 18)) begin
                random_cube(kind, c, e);
                r = $urandom_range(0, 99);
                if (r < 60) send_item(ACT_MUL, c, e);
                else if (r < 88) send_item(ACT_INV, c, e);
                else if (r < 93) send_item(ACT_SPARE, c, e);
                else if (r < 97) send_item(ACT_MUL, noise_corners(), noise_edges());
                else send_item(ACT_LOAD, c, e);
            end
        end
    endtask

    // random bits in every field
    task automatic test_noise();
        repeat (400) begin
            send_item(ACTION_W'($urandom_range(0, 3)), noise_corners(), noise_edges());
        end
    endtask

    // full rate with and without stalls on either side
    task automatic test_back_to_back();
        logic [CORNERS_W-1:0] c;
        logic [EDGES_W-1:0]   e;
        for (int phase = 0; phase < 3; phase++) begin
            steady_send = (phase != 2);
            steady_sink = (phase != 1);
            repeat (phase == 0 ? 80 : 40) begin
                random_cube(CUBE_MIRROR, c, e);
                if ($urandom_range(0, 2) == 0) send_item(ACT_INV, c, e);
                else send_item(ACT_MUL, c, e);
            end
        end
        steady_send = 1'b0;
        steady_sink = 1'b0;
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.action          = ACT_LOAD;
        cmd_ch.operand_corners = '0;
        cmd_ch.operand_edges   = '0;
        held_corners           = home_corners();
        held_edges             = home_edges();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_check_status();
        test_orientation_codes();
        test_solvable_sequences();
        test_noise();
        test_back_to_back();

        // drain outstanding results
        cmd_ch.valid = 1'b0;
        while (pending_cubes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("cube_cubie_state_compose regression: pass");
        end else begin
            $display("cube_cubie_state_compose regression: fail");
        end
        $finish;
    end

endmodule
